// ===== hw/rtl/csvss_pkg.sv =====
// types and constants shared by the csv structural scanner modules
// no dependencies
package csvss_pkg;

   localparam int LANES         = 8;
   localparam int OFFSET_BITS   = 32;
   localparam int COUNT_BITS    = 4;
   localparam int LANE_IDX_BITS = $clog2(LANES);

   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_QUOTE   = 8'h22;

   typedef logic [LANES-1:0]       lane_mask_type;
   typedef logic [LANES-1:0][7:0]  lane_bytes_type;
   typedef logic [COUNT_BITS-1:0]  lane_count_type;
   typedef logic [OFFSET_BITS-1:0] offset_type;

   typedef struct packed {
      lane_mask_type  comma;
      lane_mask_type  newline;
      lane_mask_type  quote;
      lane_count_type count;
      logic           start;
   } scan_entry_type;

endpackage

// ===== hw/rtl/csvss_front.sv =====
// front end: saturates the lane count and classifies each valid lane
// depends on csvss_pkg
module csvss_front (
   input  csvss_pkg::lane_bytes_type lane_bytes,
   input  csvss_pkg::lane_count_type valid_lanes,
   input  logic                      start_of_buffer,
   output csvss_pkg::scan_entry_type entry
);

   csvss_pkg::lane_count_type count;
   csvss_pkg::lane_mask_type  lane_valid;

   always_comb begin
      if (valid_lanes > csvss_pkg::COUNT_BITS'(csvss_pkg::LANES)) begin
         count = csvss_pkg::COUNT_BITS'(csvss_pkg::LANES);
      end else begin
         count = valid_lanes;
      end
      for (int k = 0; k < csvss_pkg::LANES; k++) begin
         lane_valid[k]    = csvss_pkg::COUNT_BITS'(k) < count;
         entry.comma[k]   = lane_valid[k] && (lane_bytes[k] == csvss_pkg::CH_COMMA);
         entry.newline[k] = lane_valid[k] && (lane_bytes[k] == csvss_pkg::CH_NEWLINE);
         entry.quote[k]   = lane_valid[k] && (lane_bytes[k] == csvss_pkg::CH_QUOTE);
      end
      entry.count = count;
      entry.start = start_of_buffer;
   end

endmodule

// ===== hw/rtl/csvss_queue.sv =====
// short queue between the classifying front end and the scanning back end
// depends on csvss_pkg
module csvss_queue #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  csvss_pkg::scan_entry_type push_data,
   output logic                      not_full,
   input  logic                      pop,
   output logic                      not_empty,
   output csvss_pkg::scan_entry_type pop_data
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   csvss_pkg::scan_entry_type slots_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign not_full  = count_ff != CNT_BITS'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !not_full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("pop from empty queue");

endmodule

// ===== hw/rtl/csvss_back.sv =====
// back end: quote prefix parity, row ends, offset tracking and result register
// depends on csvss_pkg
module csvss_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      entry_valid,
   input  csvss_pkg::scan_entry_type entry,
   output logic                      entry_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output csvss_pkg::lane_mask_type  rsp_comma_bits,
   output csvss_pkg::lane_mask_type  rsp_row_end_bits,
   output csvss_pkg::lane_mask_type  rsp_quote_bits,
   output csvss_pkg::lane_mask_type  rsp_inside_quote_bits,
   output csvss_pkg::offset_type     rsp_row_start_offset,
   output logic                      rsp_row_found
);

   logic                  carry_ff, carry_in;
   csvss_pkg::offset_type offset_ff, offset_in;
   csvss_pkg::offset_type line_base_ff, line_base_in;
   logic                  valid_ff, valid_in;

   csvss_pkg::lane_mask_type comma_ff, ends_ff, quote_ff, in_quote_ff;
   logic                     found_ff;

   logic                                 carry_eff;
   csvss_pkg::offset_type                offset_eff;
   csvss_pkg::offset_type                line_base_eff;
   csvss_pkg::lane_mask_type             parity;
   csvss_pkg::lane_mask_type             lane_valid;
   csvss_pkg::lane_mask_type             in_quote;
   csvss_pkg::lane_mask_type             ends;
   logic [csvss_pkg::LANE_IDX_BITS-1:0]  last_end;
   logic                                 acc;

   assign entry_pop = entry_valid && (!valid_ff || rsp_ready);

   always_comb begin
      carry_eff     = entry.start ? 1'b0 : carry_ff;
      offset_eff    = entry.start ? '0 : offset_ff;
      line_base_eff = entry.start ? '0 : line_base_ff;

      acc      = carry_eff;
      last_end = '0;
      for (int k = 0; k < csvss_pkg::LANES; k++) begin
         acc           = acc ^ entry.quote[k];
         parity[k]     = acc;
         lane_valid[k] = csvss_pkg::COUNT_BITS'(k) < entry.count;
         in_quote[k]   = parity[k] && lane_valid[k];
         ends[k]       = entry.newline[k] && !parity[k];
         if (ends[k]) begin
            last_end = csvss_pkg::LANE_IDX_BITS'(k);
         end
      end

      carry_in  = carry_ff;
      offset_in = offset_ff;
      line_base_in = line_base_ff;
      valid_in  = valid_ff && !rsp_ready;
      if (entry_pop) begin
         carry_in  = carry_eff ^ (^entry.quote);
         offset_in = offset_eff + csvss_pkg::OFFSET_BITS'(entry.count);
         if (|ends) begin
            line_base_in = offset_eff + csvss_pkg::OFFSET_BITS'(last_end) + 1'b1;
         end else begin
            line_base_in = line_base_eff;
         end
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff     <= 1'b0;
         offset_ff    <= '0;
         line_base_ff <= '0;
         valid_ff     <= 1'b0;
      end else begin
         carry_ff     <= carry_in;
         offset_ff    <= offset_in;
         line_base_ff <= line_base_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_pop) begin
         comma_ff    <= entry.comma;
         ends_ff     <= ends;
         quote_ff    <= entry.quote;
         in_quote_ff <= in_quote;
         found_ff    <= |ends;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_comma_bits        = comma_ff;
   assign rsp_row_end_bits      = ends_ff;
   assign rsp_quote_bits        = quote_ff;
   assign rsp_inside_quote_bits = in_quote_ff;
   assign rsp_row_start_offset  = line_base_ff;
   assign rsp_row_found         = found_ff;

   a_end_outside_quote: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (ends_ff & in_quote_ff) == '0)
      else $error("row end inside quotes");

   a_found_matches: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> found_ff == (|ends_ff))
      else $error("row_found disagrees with row end mask");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      entry_pop && entry.start && !(|entry.quote) |=> !carry_ff)
      else $error("quote carry not cleared at buffer start");

endmodule

// ===== hw/rtl/csv_structural_scanner.sv =====
// csv structural scanner: marks commas, quotes and row ends in 8-lane text words
// channels: req_ items of eight text bytes with a valid lane count and a
// start-of-buffer flag; rsp_ results with comma, quote, inside-quote and row
// end masks, the offset just past the latest row end, and a row found flag.
// both channels transfer on valid and ready high at a rising clock edge.
// the front classifies each request word into the queue, then the back end
// scans the queue head into the result register, whose valid flag drives
// rsp_valid.
// throughput is one word per cycle while rsp_ready stays high; the back end scan is combinational.
// the queue of QUEUE_DEPTH entries lets the front keep taking words while the
// result register waits; when the receiver stalls the queue fills and
// req_ready drops once it is full. results never drop or repeat.
// reset (synchronous, active high) empties the queue and the result register
// and clears quote carry, byte offset and row start to zero.
// start_of_buffer clears those three before its word is scanned.
// depends on csvss_pkg, csvss_front, csvss_queue, csvss_back
module csv_structural_scanner #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_lane_byte_0,
   input  logic [7:0]  req_lane_byte_1,
   input  logic [7:0]  req_lane_byte_2,
   input  logic [7:0]  req_lane_byte_3,
   input  logic [7:0]  req_lane_byte_4,
   input  logic [7:0]  req_lane_byte_5,
   input  logic [7:0]  req_lane_byte_6,
   input  logic [7:0]  req_lane_byte_7,
   input  logic [3:0]  req_valid_lanes,
   input  logic        req_start_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_comma_bits,
   output logic [7:0]  rsp_row_end_bits,
   output logic [7:0]  rsp_quote_bits,
   output logic [7:0]  rsp_inside_quote_bits,
   output logic [31:0] rsp_row_start_offset,
   output logic        rsp_row_found
);

   csvss_pkg::lane_bytes_type lane_bytes;
   csvss_pkg::scan_entry_type front_entry;
   csvss_pkg::scan_entry_type queue_entry;
   logic                      queue_not_full;
   logic                      queue_not_empty;
   logic                      queue_pop;
   logic                      push;

   assign lane_bytes = {req_lane_byte_7, req_lane_byte_6, req_lane_byte_5, req_lane_byte_4,
                        req_lane_byte_3, req_lane_byte_2, req_lane_byte_1, req_lane_byte_0};

   assign req_ready = queue_not_full;
   assign push      = req_valid && queue_not_full;

   csvss_front u_front (
      .lane_bytes      (lane_bytes),
      .valid_lanes     (req_valid_lanes),
      .start_of_buffer (req_start_of_buffer),
      .entry           (front_entry)
   );

   csvss_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_entry),
      .not_full  (queue_not_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_data  (queue_entry)
   );

   csvss_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .entry_valid           (queue_not_empty),
      .entry                 (queue_entry),
      .entry_pop             (queue_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_comma_bits        (rsp_comma_bits),
      .rsp_row_end_bits      (rsp_row_end_bits),
      .rsp_quote_bits        (rsp_quote_bits),
      .rsp_inside_quote_bits (rsp_inside_quote_bits),
      .rsp_row_start_offset  (rsp_row_start_offset),
      .rsp_row_found         (rsp_row_found)
   );

endmodule
